// ===== hw/rtl/gww_pkg.sv =====
// Shared types, constants and helpers for the greedy word wrap block.
package gww_pkg;

  localparam int CHAR_W     = 8;
  localparam int LW_W       = 6;
  localparam int WL_W       = 7;
  localparam int EXC_W      = 16;
  localparam int SLOTS      = 6;
  localparam int SLOT_W     = 3;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_HELD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [WL_W-1:0]   len;
    logic              last;
    logic              eot;
    logic [EXC_W-1:0]  exc;
  } cmd_t;

  function automatic cmd_t mk_char(input logic [CHAR_W-1:0] c);
    cmd_t r;
    r      = '0;
    r.kind = KIND_CHAR;
    r.ch   = c;
    return r;
  endfunction

  function automatic cmd_t mk_held(input logic [WL_W-1:0] n);
    cmd_t r;
    r      = '0;
    r.kind = KIND_HELD;
    r.len  = n;
    return r;
  endfunction

  function automatic logic [LW_W-1:0] eff_width(input logic [LW_W-1:0] lw,
                                                input logic [LW_W-1:0] maxw);
    logic [LW_W-1:0] r;
    if (lw == '0) begin
      r = LW_W'(1);
    end else if (lw > maxw) begin
      r = maxw;
    end else begin
      r = lw;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gww_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gww_queue.sv =====
// Short command queue between the classifier and the emitter.
module gww_queue
  import gww_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/gww_front.sv =====
// Front end: takes input beats, tracks line and word state, buffers word
// characters and turns each beat into a short list of output commands.
module gww_front
  import gww_pkg::*;
#(
  parameter int MAX_LINE_WIDTH    = 60,
  parameter int WORD_BUFFER_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [CHAR_W-1:0]                    in_char,
  input  logic                                 in_end_of_input,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [LW_W-1:0]                      cfg_line_width,
  output logic                                 q_push,
  output cmd_t                                 q_data,
  input  logic                                 q_full,
  input  logic                                 held_done,
  output logic                                 wr_en,
  output logic [$clog2(WORD_BUFFER_DEPTH)-1:0] wr_addr,
  output logic [CHAR_W-1:0]                    wr_data
);

  localparam int AW = $clog2(WORD_BUFFER_DEPTH);
  localparam logic [LW_W-1:0] MAXW = LW_W'(MAX_LINE_WIDTH);

  logic [LW_W-1:0]   lw_r, lw_nxt;
  logic [LW_W-1:0]   rs_r, rs_nxt;
  logic [WL_W-1:0]   wl_r, wl_nxt;
  logic              strm_r, strm_nxt;
  logic              stt_r, stt_nxt;
  logic              inw_r, inw_nxt;
  logic [1:0]        nlr_r, nlr_nxt;
  logic [EXC_W-1:0]  exc_r, exc_nxt;
  cmd_t              sl_r [SLOTS];
  cmd_t              sl_nxt [SLOTS];
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [1:0]        held_r, held_nxt;

  logic              blank, wr_needed, list_busy, accept, cfg_wr;
  logic [LW_W-1:0]   w, cfg_w;

  // per-beat working copies
  logic [LW_W-1:0]   rs;
  logic [WL_W-1:0]   wl;
  logic              strm, stt, inw, fin, has_held;
  logic [1:0]        nlr;
  logic [EXC_W-1:0]  exc;
  logic [SLOT_W-1:0] n;
  cmd_t              b [SLOTS];
  logic [WL_W-1:0]   w7;

  assign w         = eff_width(lw_r, MAXW);
  assign cfg_w     = eff_width(cfg_line_width, MAXW);
  assign w7        = {1'b0, w};
  assign blank     = ((in_char >= CH_TAB) && (in_char <= CH_CR)) || (in_char == CH_SP);
  assign wr_needed = !blank && !(inw_r && strm_r);
  assign list_busy = (idx_r != cnt_r);
  assign in_stall  = list_busy || ((held_r != '0) && wr_needed);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign q_push    = list_busy && !q_full;
  assign q_data    = sl_r[idx_r];

  always_comb begin
    rs       = rs_r;
    wl       = wl_r;
    strm     = strm_r;
    stt      = stt_r;
    inw      = inw_r;
    nlr      = nlr_r;
    exc      = exc_r;
    n        = '0;
    has_held = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wl_r[AW-1:0];
    wr_data  = in_char;
    for (int k = 0; k < SLOTS; k++) begin
      b[k] = '0;
    end
    fin = (blank && inw_r) || (!blank && in_end_of_input);

    if (blank) begin
      if (inw_r) begin
        nlr = (in_char == CH_NL) ? 2'd1 : 2'd0;
      end else if (stt_r && (in_char == CH_NL) && (nlr_r != 2'd2)) begin
        nlr = nlr_r + 2'd1;
      end
    end else begin
      if (!inw) begin
        if (stt && (nlr == 2'd2)) begin
          b[n] = mk_char(CH_NL); n = n + 1'b1;
          b[n] = mk_char(CH_NL); n = n + 1'b1;
          rs = w;
        end
        nlr  = '0;
        stt  = 1'b1;
        inw  = 1'b1;
        wl   = '0;
        strm = 1'b0;
      end
      if (strm) begin
        b[n] = mk_char(in_char); n = n + 1'b1;
      end else begin
        wr_en   = accept;
        wr_addr = wl[AW-1:0];
        if (wl != '1) begin
          wl = wl + 1'b1;
        end
        if (wl > w7) begin
          if (exc != '1) exc = exc + 1'b1;
          if (rs != w) begin
            b[n] = mk_char(CH_NL); n = n + 1'b1;
          end
          b[n] = mk_held(wl); n = n + 1'b1;
          has_held = 1'b1;
          strm = 1'b1;
        end
      end
    end

    if (fin) begin
      if (strm) begin
        b[n] = mk_char(CH_NL); n = n + 1'b1;
        rs = w;
      end else begin
        has_held = 1'b1;
        if (rs == w) begin
          if (wl >= w7) begin
            if ((wl > w7) && (exc != '1)) exc = exc + 1'b1;
            b[n] = mk_held(wl);    n = n + 1'b1;
            b[n] = mk_char(CH_NL); n = n + 1'b1;
            rs = w;
          end else begin
            b[n] = mk_held(wl); n = n + 1'b1;
            rs = LW_W'(w7 - wl);
          end
        end else if (wl > w7) begin
          if (exc != '1) exc = exc + 1'b1;
          b[n] = mk_char(CH_NL); n = n + 1'b1;
          b[n] = mk_held(wl);    n = n + 1'b1;
          b[n] = mk_char(CH_NL); n = n + 1'b1;
          rs = w;
        end else if ((wl + 1'b1) > {1'b0, rs}) begin
          b[n] = mk_char(CH_NL); n = n + 1'b1;
          b[n] = mk_held(wl);    n = n + 1'b1;
          rs = LW_W'(w7 - wl);
        end else begin
          b[n] = mk_char(CH_SP); n = n + 1'b1;
          b[n] = mk_held(wl);    n = n + 1'b1;
          rs = rs - wl[LW_W-1:0] - 1'b1;
        end
      end
      wl   = '0;
      strm = 1'b0;
      inw  = 1'b0;
    end

    if (in_end_of_input) begin
      if (!fin && stt && (nlr == 2'd2)) begin
        b[n] = mk_char(CH_NL); n = n + 1'b1;
        b[n] = mk_char(CH_NL); n = n + 1'b1;
      end
      b[n]     = mk_char(CH_NL);
      b[n].eot = 1'b1;
      b[n].exc = exc;
      n        = n + 1'b1;
      rs   = w;
      wl   = '0;
      strm = 1'b0;
      stt  = 1'b0;
      inw  = 1'b0;
      nlr  = '0;
      exc  = '0;
    end

    if (n != '0) begin
      b[n - 1'b1].last = 1'b1;
    end
  end

  always_comb begin
    lw_nxt   = lw_r;
    rs_nxt   = rs_r;
    wl_nxt   = wl_r;
    strm_nxt = strm_r;
    stt_nxt  = stt_r;
    inw_nxt  = inw_r;
    nlr_nxt  = nlr_r;
    exc_nxt  = exc_r;
    sl_nxt   = sl_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = q_push ? idx_r + 1'b1 : idx_r;
    held_nxt = held_r - 2'(held_done);
    if (accept) begin
      rs_nxt   = rs;
      wl_nxt   = wl;
      strm_nxt = strm;
      stt_nxt  = stt;
      inw_nxt  = inw;
      nlr_nxt  = nlr;
      exc_nxt  = exc;
      sl_nxt   = b;
      cnt_nxt  = n;
      idx_nxt  = '0;
      held_nxt = held_r - 2'(held_done) + 2'(has_held && (n != '0));
    end
    if (cfg_wr) begin
      lw_nxt = cfg_line_width;
      if (rs_r > cfg_w) begin
        rs_nxt = cfg_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r   <= MAXW;
      rs_r   <= MAXW;
      wl_r   <= '0;
      strm_r <= 1'b0;
      stt_r  <= 1'b0;
      inw_r  <= 1'b0;
      nlr_r  <= '0;
      exc_r  <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
      held_r <= '0;
    end else begin
      lw_r   <= lw_nxt;
      rs_r   <= rs_nxt;
      wl_r   <= wl_nxt;
      strm_r <= strm_nxt;
      stt_r  <= stt_nxt;
      inw_r  <= inw_nxt;
      nlr_r  <= nlr_nxt;
      exc_r  <= exc_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      held_r <= held_nxt;
    end
    sl_r <= sl_nxt;
  end

endmodule

// ===== hw/rtl/gww_back.sv =====
// Back end: runs queued commands, reading held words out of the buffer,
// and drives the registered output channel.
module gww_back
  import gww_pkg::*;
#(
  parameter int WORD_BUFFER_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cmd_t                                 q_head,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 held_done,
  output logic                                 rd_en,
  output logic [$clog2(WORD_BUFFER_DEPTH)-1:0] rd_addr,
  input  logic [CHAR_W-1:0]                    rd_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [CHAR_W-1:0]                    out_char,
  output logic                                 out_last_of_run,
  output logic                                 out_end_of_text,
  output logic [EXC_W-1:0]                     out_exceed_count
);

  localparam int AW = $clog2(WORD_BUFFER_DEPTH);

  logic [WL_W-1:0]   pos_r, pos_nxt;
  logic              mid_valid_r, mid_valid_nxt;
  logic              mid_ram_r;
  logic [CHAR_W-1:0] mid_ch_r;
  logic              mid_last_r, mid_eot_r;
  logic [EXC_W-1:0]  mid_exc_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r, out_eot_r;
  logic [EXC_W-1:0]  out_exc_r;

  logic              out_load, mid_take, issue, is_held, held_end;

  assign out_load  = mid_valid_r && (!out_valid_r || !out_stall);
  assign mid_take  = !mid_valid_r || out_load;
  assign issue     = !q_empty && mid_take;
  assign is_held   = (q_head.kind == KIND_HELD);
  assign held_end  = (pos_r == q_head.len - 1'b1);
  assign q_pop     = issue && (!is_held || held_end);
  assign held_done = issue && is_held && held_end;
  assign rd_en     = issue && is_held;
  assign rd_addr   = pos_r[AW-1:0];

  always_comb begin
    pos_nxt = pos_r;
    if (issue && is_held) begin
      pos_nxt = held_end ? '0 : pos_r + 1'b1;
    end
    mid_valid_nxt = issue ? 1'b1 : (out_load ? 1'b0 : mid_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (issue) begin
      mid_ram_r  <= is_held;
      mid_ch_r   <= q_head.ch;
      mid_last_r <= q_head.last && (!is_held || held_end);
      mid_eot_r  <= q_head.eot;
      mid_exc_r  <= q_head.exc;
    end
    if (out_load) begin
      out_char_r <= mid_ram_r ? rd_data : mid_ch_r;
      out_last_r <= mid_last_r;
      out_eot_r  <= mid_eot_r;
      out_exc_r  <= mid_exc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_text  = out_eot_r;
  assign out_exceed_count = out_exc_r;

endmodule

// ===== hw/rtl/greedy_word_wrap.sv =====
// Greedy word wrap: re-flows a byte stream of text to a configured line width.
//
// Input channel (in_valid / in_stall): one text byte per beat, with
// in_end_of_input marking the last byte of a text. Output channel
// (out_valid / out_stall): one output byte per beat; out_last_of_run marks
// the last byte caused by an input beat, out_end_of_text the final newline,
// which also carries out_exceed_count. Config port (cfg_valid / cfg_ready,
// always ready) sets the line width; write it between beats only.
// Each input beat is classified and expands to up to 5 queued commands,
// pushed one per cycle while the queue is not full; in_stall stays high
// until all are pushed. The back end emits one byte per cycle while the
// receiver does not stall, a held word taking one buffer read per byte.
// With nothing queued ahead, a beat's first byte passes the command list,
// the queue, the middle register and the output register. A byte that must
// go into the word buffer waits while an earlier word is still read out.
// Reset is synchronous: width returns to MAX_LINE_WIDTH, all text state
// clears. The word buffer has no reset. When the receiver stalls, the
// output register holds, the queue fills and then in_stall rises.
module greedy_word_wrap
  import gww_pkg::*;
#(
  parameter int MAX_LINE_WIDTH    = 60,
  parameter int WORD_BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_of_run,
  output logic              out_end_of_text,
  output logic [EXC_W-1:0]  out_exceed_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LW_W-1:0]   cfg_line_width
);

  localparam int AW = $clog2(WORD_BUFFER_DEPTH);

  logic              q_push, q_pop, q_empty, q_full, held_done;
  cmd_t              q_data, q_head;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CHAR_W-1:0] wr_data, rd_data;

  gww_front #(
    .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
    .WORD_BUFFER_DEPTH(WORD_BUFFER_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_end_of_input(in_end_of_input),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_width (cfg_line_width),
    .q_push         (q_push),
    .q_data         (q_data),
    .q_full         (q_full),
    .held_done      (held_done),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  gww_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  gww_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(WORD_BUFFER_DEPTH)
  ) u_word_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  gww_back #(
    .WORD_BUFFER_DEPTH(WORD_BUFFER_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .held_done       (held_done),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_end_of_text (out_end_of_text),
    .out_exceed_count(out_exceed_count)
  );

endmodule
